// ===== design/agn_pkg.sv =====
`default_nettype none

package agn_pkg;

    // Width of one character field on the ports and in the work memories
    localparam int FIELD_W = 8;

    // Gap symbol '-'
    localparam logic [FIELD_W-1:0] GAP_CODE = 8'd45;

    // Defaults for the top level parameters
    localparam int MAX_COLS_DEF  = 32;
    localparam int CHAR_BITS_DEF = 8;

    typedef logic [FIELD_W-1:0] t_char;

    // One result column as it travels to the output register
    typedef struct packed {
        t_char q;
        t_char t;
        logic  col_valid;
        logic  ovf;
        logic  last;
    } t_res;

endpackage

`default_nettype wire

// ===== design/agn_col_if.sv =====
`default_nettype none

interface agn_col_if;
    logic                        valid;
    logic                        ready;
    logic [agn_pkg::FIELD_W-1:0] query_char;
    logic [agn_pkg::FIELD_W-1:0] target_char;
    logic                        final_column;

    modport source (
        output valid, query_char, target_char, final_column,
        input  ready
    );
    modport sink (
        input  valid, query_char, target_char, final_column,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/agn_res_if.sv =====
`default_nettype none

interface agn_res_if;
    logic                        valid;
    logic                        ready;
    logic [agn_pkg::FIELD_W-1:0] out_query_char;
    logic [agn_pkg::FIELD_W-1:0] out_target_char;
    logic                        column_valid;
    logic                        overflow;
    logic                        last_out;

    modport source (
        output valid, out_query_char, out_target_char, column_valid, overflow, last_out,
        input  ready
    );
    modport sink (
        input  valid, out_query_char, out_target_char, column_valid, overflow, last_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/agn_ram.sv =====
`default_nettype none

module agn_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/agn_seq.sv =====
`default_nettype none

module agn_seq #(
    parameter int MAX_COLS  = agn_pkg::MAX_COLS_DEF,
    parameter int CHAR_BITS = agn_pkg::CHAR_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    agn_col_if.sink                               i_col,
    // work memory ports, shared address for both columns stores
    output      logic [$clog2(2*MAX_COLS)-1:0]    o_raddr,
    output      logic [$clog2(2*MAX_COLS)-1:0]    o_waddr,
    output      logic                             o_we_q,
    output      logic                             o_we_t,
    output      logic [agn_pkg::FIELD_W-1:0]      o_wq,
    output      logic [agn_pkg::FIELD_W-1:0]      o_wt,
    input  wire logic [agn_pkg::FIELD_W-1:0]      i_rq,
    input  wire logic [agn_pkg::FIELD_W-1:0]      i_rt,
    // result beats towards the output register
    input  wire logic                             i_out_free,
    output      logic                             o_push,
    output      agn_pkg::t_res                    o_beat
);

    import agn_pkg::*;

    localparam int WORK_DEPTH = 2 * MAX_COLS;
    localparam int AW         = $clog2(WORK_DEPTH);
    localparam int LW         = $clog2(WORK_DEPTH + 1);
    localparam int CNTW       = $clog2(MAX_COLS + 1);

    typedef enum logic [8:0] {
        S_LOAD   = 9'b000000001,
        S_SPLIT  = 9'b000000010,
        S_POS    = 9'b000000100,
        S_TSRCH  = 9'b000001000,
        S_QSRCH  = 9'b000010000,
        S_WB     = 9'b000100000,
        S_ESTART = 9'b001000000,
        S_EMIT   = 9'b010000000,
        S_FLUSH  = 9'b100000000
    } t_state;

    t_state          r_state, n_state;
    logic [CNTW-1:0] r_cols,  n_cols;
    logic [LW-1:0]   r_len,   n_len;
    logic            r_ovf,   n_ovf;
    logic            r_final, n_final;
    logic            r_pv,    n_pv;
    t_char           r_sq,    n_sq;
    t_char           r_q,     n_q;
    t_char           r_t,     n_t;
    t_char           r_pq,    n_pq;
    t_char           r_pt,    n_pt;
    logic [AW-1:0]   r_i,     n_i;
    logic [AW-1:0]   r_ptr,   n_ptr;

    t_char           w_mq;
    t_char           w_mt;
    logic            w_split;
    logic            w_more;
    logic            w_next_pos;
    logic            w_dbl_gap;

    assign w_mq    = FIELD_W'(i_col.query_char[CHAR_BITS-1:0]);
    assign w_mt    = FIELD_W'(i_col.target_char[CHAR_BITS-1:0]);
    assign w_split = (w_mq != w_mt) && (w_mq != GAP_CODE) && (w_mt != GAP_CODE);

    // another stored column lies right of the read pointer
    assign w_more     = (LW'(r_ptr) + LW'(1)) < r_len;
    // another scan position remains after this one
    assign w_next_pos = (LW'(r_i) + LW'(2)) < r_len;
    assign w_dbl_gap  = (i_rq == GAP_CODE) && (i_rt == GAP_CODE);

    assign i_col.ready = (r_state == S_LOAD);
    assign o_raddr     = n_ptr;

    always_comb begin
        n_state = r_state;
        n_cols  = r_cols;
        n_len   = r_len;
        n_ovf   = r_ovf;
        n_final = r_final;
        n_pv    = r_pv;
        n_sq    = r_sq;
        n_q     = r_q;
        n_t     = r_t;
        n_pq    = r_pq;
        n_pt    = r_pt;
        n_i     = r_i;
        n_ptr   = r_ptr;
        o_waddr = r_len[AW-1:0];
        o_we_q  = 1'b0;
        o_we_t  = 1'b0;
        o_wq    = w_mq;
        o_wt    = w_mt;
        o_push  = 1'b0;
        o_beat  = '{q: r_pq, t: r_pt, col_valid: 1'b1, ovf: r_ovf, last: 1'b0};

        unique case (r_state)
            S_LOAD: begin
                if (i_col.valid) begin
                    n_final = i_col.final_column;
                    if (r_cols < CNTW'(MAX_COLS)) begin
                        n_cols = r_cols + CNTW'(1);
                        n_len  = r_len + LW'(1);
                        o_we_q = 1'b1;
                        o_we_t = 1'b1;
                        if (w_split) begin
                            // first half of the split: (gap, target)
                            o_wq    = GAP_CODE;
                            n_sq    = w_mq;
                            n_state = S_SPLIT;
                        end else if (i_col.final_column) begin
                            n_i     = '0;
                            n_ptr   = '0;
                            n_state = ((r_len + LW'(1)) < LW'(2)) ? S_ESTART : S_POS;
                        end
                    end else begin
                        n_ovf = 1'b1;
                        if (i_col.final_column) begin
                            n_i     = '0;
                            n_ptr   = '0;
                            n_state = (r_len < LW'(2)) ? S_ESTART : S_POS;
                        end
                    end
                end
            end
            S_SPLIT: begin
                // second half of the split: (query, gap)
                o_we_q = 1'b1;
                o_we_t = 1'b1;
                o_wq   = r_sq;
                o_wt   = GAP_CODE;
                n_len  = r_len + LW'(1);
                if (r_final) begin
                    n_i     = '0;
                    n_ptr   = '0;
                    n_state = S_POS;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_POS: begin
                n_q = i_rq;
                n_t = i_rt;
                if (i_rt == GAP_CODE) begin
                    n_ptr   = r_i + AW'(1);
                    n_state = S_TSRCH;
                end else if (i_rq == GAP_CODE) begin
                    n_ptr   = r_i + AW'(1);
                    n_state = S_QSRCH;
                end else begin
                    n_state = S_WB;
                end
            end
            S_TSRCH: begin
                if (i_rt != GAP_CODE || !w_more) begin
                    if (i_rt != GAP_CODE && i_rt == r_q) begin
                        o_we_t  = 1'b1;
                        o_waddr = r_ptr;
                        o_wt    = GAP_CODE;
                        n_t     = i_rt;
                    end
                    if (r_q == GAP_CODE) begin
                        n_ptr   = r_i + AW'(1);
                        n_state = S_QSRCH;
                    end else begin
                        n_state = S_WB;
                    end
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_QSRCH: begin
                if (i_rq != GAP_CODE || !w_more) begin
                    if (i_rq != GAP_CODE && i_rq == r_t) begin
                        o_we_q  = 1'b1;
                        o_waddr = r_ptr;
                        o_wq    = GAP_CODE;
                        n_q     = i_rq;
                    end
                    n_state = S_WB;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_WB: begin
                o_we_q  = 1'b1;
                o_we_t  = 1'b1;
                o_waddr = r_i;
                o_wq    = r_q;
                o_wt    = r_t;
                if (w_next_pos) begin
                    n_i     = r_i + AW'(1);
                    n_ptr   = r_i + AW'(1);
                    n_state = S_POS;
                end else begin
                    n_state = S_ESTART;
                end
            end
            S_ESTART: begin
                n_ptr   = '0;
                n_state = (r_len == '0) ? S_FLUSH : S_EMIT;
            end
            S_EMIT: begin
                if (w_dbl_gap || !r_pv || i_out_free) begin
                    if (!w_dbl_gap) begin
                        o_push = r_pv;
                        n_pv   = 1'b1;
                        n_pq   = i_rq;
                        n_pt   = i_rt;
                    end
                    if (w_more) begin
                        n_ptr = r_ptr + AW'(1);
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                o_beat.last = 1'b1;
                if (!r_pv) begin
                    o_beat.q         = '0;
                    o_beat.t         = '0;
                    o_beat.col_valid = 1'b0;
                end
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_pv    = 1'b0;
                    n_len   = '0;
                    n_cols  = '0;
                    n_ovf   = 1'b0;
                    n_final = 1'b0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cols  <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_final <= 1'b0;
            r_pv    <= 1'b0;
            r_i     <= '0;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_cols  <= n_cols;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_final <= n_final;
            r_pv    <= n_pv;
            r_i     <= n_i;
            r_ptr   <= n_ptr;
        end
        r_sq <= n_sq;
        r_q  <= n_q;
        r_t  <= n_t;
        r_pq <= n_pq;
        r_pt <= n_pt;
    end

endmodule

`default_nettype wire

// ===== design/alignment_gap_normalizer_top.sv =====
// Alignment gap normaliser.
// i_col takes one alignment column per beat: query and target characters ('-' is a
// gap) and final_column on the last column. Characters are masked to CHAR_BITS bits.
// Up to MAX_COLS columns are held; further columns are dropped and every result of
// that alignment carries overflow. A mismatch column is split on the way into two
// indel columns of the work memories (2*MAX_COLS entries, one read and one write
// port each).
// The final beat starts the gap-push scan: each position is read, followed by a
// target or query search where one side holds a gap, and written back, the single
// read port of each memory setting the pace. Emission then reads one work column
// per cycle unless a stall on o_res holds it, drops all-gap columns and sends o_res
// beats with last_out on the final one; an empty alignment gives one beat with
// column_valid low.
// i_col is held off (ready low) from the final beat until the last result has been
// handed to the output register. A stall on o_res holds the scan of the emission
// in place; no result is lost. Reset clears the column count and overflow flag
// and empties the output register; memory contents need no clearing.
`default_nettype none

module alignment_gap_normalizer_top #(
    parameter int MAX_COLS  = agn_pkg::MAX_COLS_DEF,
    parameter int CHAR_BITS = agn_pkg::CHAR_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    agn_col_if.sink   i_col,
    agn_res_if.source o_res
);

    import agn_pkg::*;

    localparam int WORK_DEPTH = 2 * MAX_COLS;
    localparam int AW         = $clog2(WORK_DEPTH);

    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_waddr;
    logic          w_we_q;
    logic          w_we_t;
    t_char         w_wq;
    t_char         w_wt;
    t_char         w_rq;
    t_char         w_rt;
    logic          w_out_free;
    logic          w_push;
    t_res          w_beat;

    logic          r_ov;
    t_res          r_beat;

    // query side of the work alignment
    agn_ram #(
        .DEPTH (WORK_DEPTH),
        .WIDTH (FIELD_W)
    ) u_qmem (
        .i_clk   (i_clk),
        .i_we    (w_we_q),
        .i_waddr (w_waddr),
        .i_wdata (w_wq),
        .i_raddr (w_raddr),
        .o_rdata (w_rq)
    );

    // target side of the work alignment
    agn_ram #(
        .DEPTH (WORK_DEPTH),
        .WIDTH (FIELD_W)
    ) u_tmem (
        .i_clk   (i_clk),
        .i_we    (w_we_t),
        .i_waddr (w_waddr),
        .i_wdata (w_wt),
        .i_raddr (w_raddr),
        .o_rdata (w_rt)
    );

    agn_seq #(
        .MAX_COLS  (MAX_COLS),
        .CHAR_BITS (CHAR_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_col      (i_col),
        .o_raddr    (w_raddr),
        .o_waddr    (w_waddr),
        .o_we_q     (w_we_q),
        .o_we_t     (w_we_t),
        .o_wq       (w_wq),
        .o_wt       (w_wt),
        .i_rq       (w_rq),
        .i_rt       (w_rt),
        .i_out_free (w_out_free),
        .o_push     (w_push),
        .o_beat     (w_beat)
    );

    // Output register: take a new beat when empty or when the current one leaves
    assign w_out_free = !r_ov || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_free) begin
            r_ov <= w_push;
        end
        if (w_out_free && w_push) begin
            r_beat <= w_beat;
        end
    end

    assign o_res.valid           = r_ov;
    assign o_res.out_query_char  = r_beat.q;
    assign o_res.out_target_char = r_beat.t;
    assign o_res.column_valid    = r_beat.col_valid;
    assign o_res.overflow        = r_beat.ovf;
    assign o_res.last_out        = r_beat.last;

endmodule

`default_nettype wire
